// File: sv/ahps_pkg.sv
// ----------------------------------------------------------------------------
// ahps_pkg: shared types and constants of the primary hit selector
// holds limits, outcome codes, register indexes and controller state codes, but no struct
// ----------------------------------------------------------------------------
`default_nettype none

package ahps_pkg;

  localparam int unsigned LOCUS_DEPTH = 256;
  localparam logic [15:0] DEFAULT_WINDOW = 16'd50;
  localparam logic [8:0] COUNT_MAX = 9'd511;

  typedef enum logic [1:0] {
    OUT_RAISED = 2'd0,
    OUT_UNIQUE_HIGH = 2'd1,
    OUT_MULTI = 2'd2,
    OUT_NO_EVIDENCE = 2'd3
  } outcome_e;

  typedef enum logic [0:0] {
    REG_DELTA = 1'b0,
    REG_UNIQUE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// File: sv/ahps_cell.sv
// ----------------------------------------------------------------------------
// ahps_cell: one locus slot of the locus chain
// holds a stored locus, compares a probe and passes the probe on
// ----------------------------------------------------------------------------
`default_nettype none

module ahps_cell #(
  parameter int unsigned CB = 16,
  parameter int unsigned PB = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic          load_i,
  input  logic          p_vld_i,
  input  logic [CB-1:0] p_contig_i,
  input  logic [PB-1:0] p_pos_i,
  input  logic [15:0]   p_win_i,
  input  logic          p_hit_i,
  output logic          p_vld_o,
  output logic [CB-1:0] p_contig_o,
  output logic [PB-1:0] p_pos_o,
  output logic [15:0]   p_win_o,
  output logic          p_hit_o
);

  logic          used_q;
  logic [CB-1:0] contig_q;
  logic [PB-1:0] pos_q;
  logic          vld_q, hit_q;
  logic [CB-1:0] pc_q;
  logic [PB-1:0] pp_q;
  logic [15:0]   pw_q;
  logic [PB-1:0] diff;
  logic          match;

  assign diff = (p_pos_i >= pos_q) ? p_pos_i - pos_q : pos_q - p_pos_i;
  // both sides widened to PB+16 bits so any position width compares exactly
  assign match = used_q && (contig_q == p_contig_i) &&
                 ({16'd0, diff} <= {{PB{1'b0}}, p_win_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      vld_q <= p_vld_i;
      hit_q <= p_hit_i | match;
      if (clear_i) begin
        used_q <= 1'b0;
      end else if (load_i) begin
        used_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q <= p_contig_i;
    pp_q <= p_pos_i;
    pw_q <= p_win_i;
    if (load_i) begin
      contig_q <= p_contig_i;
      pos_q <= p_pos_i;
    end
  end

  assign p_vld_o = vld_q;
  assign p_hit_o = hit_q;
  assign p_contig_o = pc_q;
  assign p_pos_o = pp_q;
  assign p_win_o = pw_q;

endmodule

`default_nettype wire

// File: sv/alignment_hit_primary_selector_unit.sv
// ----------------------------------------------------------------------------
// alignment_hit_primary_selector_unit: primary hit selector for one read
// ----------------------------------------------------------------------------
// usage
//   hits of one read arrive on the in channel (valid_i / stall_o), the
//   record's own placement first, last_hit_i on the final one
//   one result word per read leaves on the out channel (valid_o / stall_i)
//   config writes (cfg_valid_i / cfg_ready_o) set distance delta and unique
//   mapq; the user must write only while idle, the block does not check it
// hit walk
//   a primary hit walks a probe through a chain of 256 locus cells, one
//   cell per cycle; stall_o stays high until its walk is done
//   the result is registered in the cycle after the last hit finishes
// reset
//   clears per-read state and all cell used bits; delta 1, unique mapq 60
// stall
//   the result register holds while stall_i is high; the next hit is only
//   taken once the result has left
// ----------------------------------------------------------------------------
`default_nettype none

module alignment_hit_primary_selector_unit
  import ahps_pkg::*;
#(
  parameter int unsigned MAX_HITS = 256,
  parameter int unsigned CONTIG_BITS = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [CONTIG_BITS-1:0]   contig_id_i,
  input  logic                     is_primary_i,
  input  logic [POSITION_BITS-1:0] position_i,
  input  logic [7:0]               edit_distance_i,
  input  logic                     cigar_valid_i,
  input  logic [15:0]              read_length_i,
  input  logic [7:0]               record_mapq_i,
  input  logic                     last_hit_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic                     promote_o,
  output logic [7:0]               promoted_index_o,
  output logic [7:0]               new_mapq_o,
  output logic [1:0]               outcome_o,
  output logic [8:0]               primary_loci_o,
  output logic [8:0]               unplaced_hits_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [7:0]               cfg_data_i
);

  localparam int unsigned HC_BITS = $clog2(MAX_HITS + 1);
  localparam int unsigned N = LOCUS_DEPTH;

  state_e state_q, state_d;

  logic [7:0] delta_q, umapq_q;
  logic [HC_BITS-1:0] hit_cnt_q;
  logic [7:0] least_q, tdist_q, held_q;
  logic [HC_BITS-1:0] tidx_q;
  logic tvalid_q, tcig_q, rprim_q;
  logic [15:0] win_q;
  logic [8:0] unpl_q, loci_q;
  // hit being walked
  logic [CONTIG_BITS-1:0] h_contig_q;
  logic [POSITION_BITS-1:0] h_pos_q;
  logic h_prim_q, h_last_q, h_take_q, h_go_q;

  // chain wiring
  logic c_vld [N+1];
  logic c_hit [N+1];
  logic [CONTIG_BITS-1:0] c_contig [N+1];
  logic [POSITION_BITS-1:0] c_pos [N+1];
  logic [15:0] c_win [N+1];
  logic [N-1:0] load;
  logic clear;
  logic accept, take, walk_done, store_new;
  logic [15:0] win_use;

  assign accept = valid_i && !stall_o;
  assign stall_o = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign take = hit_cnt_q < HC_BITS'(MAX_HITS);
  assign win_use = (hit_cnt_q == '0) ? ((read_length_i != 16'd0) ? read_length_i
                   : DEFAULT_WINDOW) : win_q;

  // the probe enters in the cycle after accept, from the held hit, so every
  // cell's pass-through copy equals the held hit when the walk ends
  assign c_vld[0] = h_go_q;
  assign c_hit[0] = 1'b0;
  assign c_contig[0] = h_contig_q;
  assign c_pos[0] = h_pos_q;
  assign c_win[0] = win_q;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      ahps_cell #(.CB(CONTIG_BITS), .PB(POSITION_BITS)) u_cell (
        .clk_i(clk_i), .rst_ni(rst_ni), .clear_i(clear), .load_i(load[g]),
        .p_vld_i(c_vld[g]), .p_contig_i(c_contig[g]), .p_pos_i(c_pos[g]),
        .p_win_i(c_win[g]), .p_hit_i(c_hit[g]),
        .p_vld_o(c_vld[g+1]), .p_contig_o(c_contig[g+1]), .p_pos_o(c_pos[g+1]),
        .p_win_o(c_win[g+1]), .p_hit_o(c_hit[g+1])
      );
    end
  endgenerate

  // the probe leaving the chain carries a dup flag; a new locus fills the
  // next free slot (slots fill in order)
  assign walk_done = c_vld[N];
  assign store_new = walk_done && !c_hit[N] && (loci_q < 9'(N));
  always_comb begin
    load = '0;
    if (store_new) load[loci_q[7:0]] = 1'b1;
  end

  // result
  logic promote, on_prim, fire;
  logic [8:0] lsum;
  assign lsum = {1'b0, least_q} + {1'b0, delta_q};
  assign promote = !rprim_q && tvalid_q && (tidx_q != '0) &&
                   ({1'b0, tdist_q} <= lsum) && tcig_q;
  assign on_prim = rprim_q || promote;

  logic ov_q;
  logic [7:0] o_idx_q, o_mapq_q;
  logic o_prom_q;
  logic [1:0] o_out_q;
  logic [8:0] o_loci_q, o_unpl_q;

  assign clear = (state_q == ST_OUT) && !stall_i && ov_q;
  assign fire = (state_q == ST_WALK) && (h_take_q && h_prim_q ? walk_done : 1'b1)
                && h_last_q && !ov_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_WALK;
      ST_WALK: begin
        if (!h_take_q || !h_prim_q || walk_done) begin
          state_d = h_last_q ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: if (ov_q && !stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      delta_q <= 8'd1;
      umapq_q <= 8'd60;
      hit_cnt_q <= '0;
      least_q <= '0;
      tvalid_q <= 1'b0;
      tidx_q <= '0;
      tdist_q <= '0;
      tcig_q <= 1'b0;
      rprim_q <= 1'b0;
      held_q <= '0;
      win_q <= DEFAULT_WINDOW;
      unpl_q <= '0;
      loci_q <= '0;
      ov_q <= 1'b0;
      h_prim_q <= 1'b0;
      h_last_q <= 1'b0;
      h_take_q <= 1'b0;
      h_go_q <= 1'b0;
      o_prom_q <= 1'b0;
      o_idx_q <= '0;
      o_mapq_q <= '0;
      o_out_q <= '0;
      o_loci_q <= '0;
      o_unpl_q <= '0;
    end else begin
      state_q <= state_d;
      h_go_q <= accept && take && is_primary_i;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_DELTA: delta_q <= cfg_data_i;
          REG_UNIQUE: umapq_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        h_prim_q <= is_primary_i;
        h_last_q <= last_hit_i;
        h_take_q <= take;
        if (take) begin
          if (hit_cnt_q == '0) begin
            rprim_q <= is_primary_i;
            held_q <= record_mapq_i;
            win_q <= win_use;
            least_q <= edit_distance_i;
          end else if (edit_distance_i < least_q) begin
            least_q <= edit_distance_i;
          end
          if (is_primary_i) begin
            if (!tvalid_q || edit_distance_i < tdist_q) begin
              tvalid_q <= 1'b1;
              tidx_q <= hit_cnt_q;
              tdist_q <= edit_distance_i;
              tcig_q <= cigar_valid_i;
            end
          end else if (unpl_q != COUNT_MAX) begin
            unpl_q <= unpl_q + 9'd1;
          end
          hit_cnt_q <= hit_cnt_q + 1'b1;
        end
      end
      if (store_new) loci_q <= loci_q + 9'd1;
      if (fire) begin
        ov_q <= 1'b1;
        o_prom_q <= promote;
        o_idx_q <= promote ? 8'(tidx_q) : 8'd0;
        o_loci_q <= loci_q + (store_new ? 9'd1 : 9'd0);
        o_unpl_q <= unpl_q;
        o_mapq_q <= held_q;
        if (on_prim && (loci_q + (store_new ? 9'd1 : 9'd0)) == 9'd1 && unpl_q != 0)
        begin
          if (held_q < umapq_q) begin
            o_mapq_q <= umapq_q;
            o_out_q <= OUT_RAISED;
          end else begin
            o_out_q <= OUT_UNIQUE_HIGH;
          end
        end else if ((loci_q + (store_new ? 9'd1 : 9'd0)) >= 9'd2) begin
          o_out_q <= OUT_MULTI;
        end else begin
          o_out_q <= OUT_NO_EVIDENCE;
        end
      end
      if (clear) begin
        ov_q <= 1'b0;
        hit_cnt_q <= '0;
        least_q <= '0;
        tvalid_q <= 1'b0;
        tidx_q <= '0;
        tdist_q <= '0;
        tcig_q <= 1'b0;
        rprim_q <= 1'b0;
        held_q <= '0;
        win_q <= DEFAULT_WINDOW;
        unpl_q <= '0;
        loci_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      h_contig_q <= contig_id_i;
      h_pos_q <= position_i;
    end
  end

  assign valid_o = ov_q;
  assign promote_o = o_prom_q;
  assign promoted_index_o = o_idx_q;
  assign new_mapq_o = o_mapq_q;
  assign outcome_o = o_out_q;
  assign primary_loci_o = o_loci_q;
  assign unplaced_hits_o = o_unpl_q;

endmodule

`default_nettype wire

// File: sv/ahps_checker.sv
// ----------------------------------------------------------------------------
// ahps_sva: port-level checks of the primary hit selector
// ----------------------------------------------------------------------------
`default_nettype none

module ahps_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       stall_o,
  input logic       valid_o,
  input logic       stall_i,
  input logic       promote_o,
  input logic [7:0] promoted_index_o,
  input logic [1:0] outcome_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o) else $error("input open with result pending");
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !promote_o |-> promoted_index_o == 8'd0) else $error("index");
  a_prom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && promote_o |-> promoted_index_o != 8'd0)
    else $error("promote idx zero");

endmodule

bind alignment_hit_primary_selector_unit ahps_sva u_ahps_sva (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
  .valid_o(valid_o), .stall_i(stall_i), .promote_o(promote_o),
  .promoted_index_o(promoted_index_o), .outcome_o(outcome_o)
);

`default_nettype wire

// File: dv/ahps_checker.sv
// ----------------------------------------------------------------------------
// ahps_checker: result checker for the primary hit selector
// predicts each result word from the accepted hit words and config writes,
// compares every accepted result word, all fields at once, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ahps_checker
  import ahps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [15:0] contig_id_i,
  input  logic        is_primary_i,
  input  logic [31:0] position_i,
  input  logic [7:0]  edit_distance_i,
  input  logic        cigar_valid_i,
  input  logic [15:0] read_length_i,
  input  logic [7:0]  record_mapq_i,
  input  logic        last_hit_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic        promote_o,
  input  logic [7:0]  promoted_index_o,
  input  logic [7:0]  new_mapq_o,
  input  logic [1:0]  outcome_o,
  input  logic [8:0]  primary_loci_o,
  input  logic [8:0]  unplaced_hits_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          mismatch_count_o,
  output int          pending_o,
  output int          reads_done_o
);

  typedef struct packed {
    logic       promote;
    logic [7:0] index;
    logic [7:0] mapq;
    outcome_e   outcome;
    logic [8:0] loci;
    logic [8:0] unplaced;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [7:0]  delta_r, unique_r;
  int unsigned hits_seen, best_dist, tgt_idx, tgt_dist, loci_n, unpl_n;
  bit          tgt_ok, tgt_cig, own_primary;
  logic [7:0]  first_mapq;
  logic [15:0] window;
  logic [15:0] locus_ctg[LOCUS_DEPTH];
  logic [31:0] locus_pos[LOCUS_DEPTH];

  function automatic void clear_read();
    hits_seen = 0; best_dist = 0; tgt_ok = 0; tgt_idx = 0; tgt_dist = 0;
    tgt_cig = 0; own_primary = 0; first_mapq = 0; window = DEFAULT_WINDOW;
    loci_n = 0; unpl_n = 0;
  endfunction

  // fold one hit word into the per-read summary
  function automatic void absorb_hit();
    bit          dup;
    logic [31:0] d;
    dup = 0;
    if (hits_seen == 0) begin
      own_primary = is_primary_i;
      first_mapq = record_mapq_i;
      window = (read_length_i != 0) ? read_length_i : DEFAULT_WINDOW;
      best_dist = edit_distance_i;
    end else if (edit_distance_i < best_dist) begin
      best_dist = edit_distance_i;
    end
    if (is_primary_i) begin
      if (!tgt_ok || edit_distance_i < tgt_dist) begin
        tgt_ok = 1; tgt_idx = hits_seen; tgt_dist = edit_distance_i;
        tgt_cig = cigar_valid_i;
      end
      for (int j = 0; j < loci_n && !dup; j++) begin
        if (locus_ctg[j] == contig_id_i) begin
          d = (position_i >= locus_pos[j]) ? position_i - locus_pos[j]
                                           : locus_pos[j] - position_i;
          if (d <= window) dup = 1;
        end
      end
      if (!dup && loci_n < LOCUS_DEPTH) begin
        locus_ctg[loci_n] = contig_id_i;
        locus_pos[loci_n] = position_i;
        loci_n++;
      end
    end else begin
      unpl_n++;
    end
    hits_seen++;
  endfunction

  function automatic verdict_t close_read();
    verdict_t v;
    bit       on_prim;
    v.promote = !own_primary && tgt_ok && tgt_idx > 0 &&
                tgt_dist <= best_dist + delta_r && tgt_cig;
    on_prim = own_primary || v.promote;
    v.index = v.promote ? tgt_idx[7:0] : 8'd0;
    v.mapq = first_mapq;
    if (on_prim && loci_n == 1 && unpl_n >= 1) begin
      if (first_mapq < unique_r) begin
        v.mapq = unique_r;
        v.outcome = OUT_RAISED;
      end else begin
        v.outcome = OUT_UNIQUE_HIGH;
      end
    end else if (loci_n >= 2) begin
      v.outcome = OUT_MULTI;
    end else begin
      v.outcome = OUT_NO_EVIDENCE;
    end
    v.loci = (loci_n > COUNT_MAX) ? COUNT_MAX : loci_n[8:0];
    v.unplaced = (unpl_n > COUNT_MAX) ? COUNT_MAX : unpl_n[8:0];
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v, got_v;
    if (!rst_ni) begin
      delta_r = 8'd1;
      unique_r = 8'd60;
      clear_read();
      verdict_q.delete();
      mismatch_count_o = 0;
      reads_done_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_idx_e'(cfg_index_i))
          REG_DELTA:  delta_r = cfg_data_i;
          REG_UNIQUE: unique_r = cfg_data_i;
          default: ;
        endcase
      end
      if (valid_o && !stall_i) begin
        got_v = '{promote_o, promoted_index_o, new_mapq_o, outcome_e'(outcome_o),
                  primary_loci_o, unplaced_hits_o};
        if (verdict_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("unexpected result word: %p", got_v);
        end else begin
          exp_v = verdict_q.pop_front();
          reads_done_o++;
          if (got_v !== exp_v) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("result mismatch: expected %p, got %p", exp_v, got_v);
          end
        end
      end
      if (valid_i && !stall_o) begin
        if (hits_seen < 256) absorb_hit();
        if (last_hit_i) begin
          verdict_q.push_back(close_read());
          clear_read();
        end
      end
    end
  end

  assign pending_o = verdict_q.size();

endmodule

// File: dv/tb_alignment_hit_primary_selector_unit.sv
// ----------------------------------------------------------------------------
// tb_alignment_hit_primary_selector_unit: testbench for the hit selector
// streams reads of candidate hits, directed corner reads first and then
// random reads, under three idle profiles and several register settings;
// a checker beside the block predicts and compares each result word
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_alignment_hit_primary_selector_unit;
  import ahps_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [15:0] contig_id_i = '0;
  logic        is_primary_i = 1'b0;
  logic [31:0] position_i = '0;
  logic [7:0]  edit_distance_i = '0;
  logic        cigar_valid_i = 1'b0;
  logic [15:0] read_length_i = '0;
  logic [7:0]  record_mapq_i = '0;
  logic        last_hit_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic        promote_o;
  logic [7:0]  promoted_index_o, new_mapq_o;
  logic [1:0]  outcome_o;
  logic [8:0]  primary_loci_o, unplaced_hits_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;

  int mismatch_count, pending, reads_done;
  int send_idle_pct, recv_idle_pct;
  longint cycle_count;
  int words_sent;

  // primary hits walk the whole locus chain, so the limit is set from that
  localparam longint CYCLE_LIMIT = 64'd8_000_000;

  always #5 clk_i = ~clk_i;

  alignment_hit_primary_selector_unit u_dut (.*);

  ahps_checker u_chk (
    .*,
    .mismatch_count_o(mismatch_count),
    .pending_o(pending),
    .reads_done_o(reads_done)
  );

  // receiver stall, redrawn every falling edge
  always @(negedge clk_i)
    stall_i <= ($urandom_range(99) < recv_idle_pct);

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // drive one hit word and hold it until accepted
  task automatic send_hit(input logic [15:0] ctg, input logic prim,
                          input logic [31:0] pos, input logic [7:0] edist,
                          input logic cig, input logic [15:0] rlen,
                          input logic [7:0] mq, input logic last);
    logic busy;
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    contig_id_i <= ctg; is_primary_i <= prim; position_i <= pos;
    edit_distance_i <= edist; cigar_valid_i <= cig; read_length_i <= rlen;
    record_mapq_i <= mq; last_hit_i <= last;
    // stall is sampled between edges, where it is stable
    busy = stall_o;
    @(posedge clk_i);
    while (busy) begin
      @(negedge clk_i);
      busy = stall_o;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    valid_i <= 1'b0;
    @(negedge clk_i);
    words_sent++;
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input reg_idx_e idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  // one random read: mostly primary hits near a few loci plus unplaced hits
  task automatic random_read(input int nhits);
    logic [15:0] base_ctg, rlen;
    logic [31:0] base_pos;
    logic [7:0]  mq;
    logic        prim;
    base_ctg = 16'($urandom_range(3));
    base_pos = $urandom;
    rlen = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(300));
    if ($urandom_range(15) == 0) rlen = 16'($urandom);
    mq = 8'($urandom);
    for (int h = 0; h < nhits; h++) begin
      prim = $urandom_range(2) != 0;
      if ($urandom_range(9) == 0)
        send_hit(16'($urandom), prim, $urandom, 8'($urandom), 1'($urandom),
                 16'($urandom), mq, h == nhits - 1);
      else
        send_hit(base_ctg + 16'($urandom_range(1)), prim,
                 base_pos + 32'($urandom_range(400)) - 32'd200,
                 8'($urandom_range(6)), $urandom_range(3) != 0, rlen, mq,
                 h == nhits - 1);
    end
  endtask

  initial begin
    send_idle_pct = 23;
    recv_idle_pct = 80;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed reads
    // single primary hit, own placement
    send_hit(16'h0000, 1'b1, 32'h0000_0000, 8'h00, 1'b1, 16'h0000, 8'h00, 1'b1);
    // unplaced record, better primary alt with good cigar, mapq raised
    send_hit(16'hffff, 1'b0, 32'hffff_ffff, 8'hff, 1'b0, 16'hffff, 8'h00, 1'b0);
    send_hit(16'h0001, 1'b1, 32'h0000_1000, 8'h01, 1'b1, 16'h0000, 8'hff, 1'b1);
    // primary target with bad cigar, no promotion
    send_hit(16'h0005, 1'b0, 32'h10, 8'h03, 1'b1, 16'd100, 8'd10, 1'b0);
    send_hit(16'h0002, 1'b1, 32'h20, 8'h03, 1'b0, 16'h0, 8'h0, 1'b1);
    // two loci, same contig, outside window (read length zero gives 50)
    send_hit(16'h0003, 1'b1, 32'd1000, 8'd2, 1'b1, 16'd0, 8'd70, 1'b0);
    send_hit(16'h0003, 1'b1, 32'd1051, 8'd2, 1'b1, 16'd0, 8'd0, 1'b0);
    send_hit(16'h0003, 1'b1, 32'd1050, 8'd2, 1'b1, 16'd0, 8'd0, 1'b1);
    // unique on primary, mapq already high
    send_hit(16'h0004, 1'b1, 32'd5, 8'd9, 1'b1, 16'd20, 8'd200, 1'b0);
    send_hit(16'h0100, 1'b0, 32'd5, 8'd1, 1'b1, 16'd0, 8'd0, 1'b1);
    // target outside the distance slack
    send_hit(16'h0100, 1'b0, 32'd5, 8'd0, 1'b1, 16'd20, 8'd3, 1'b0);
    send_hit(16'h0007, 1'b1, 32'd5, 8'd2, 1'b1, 16'd20, 8'd3, 1'b1);
    drain();

    // extreme register settings
    write_reg(REG_DELTA, 8'hff);
    write_reg(REG_UNIQUE, 8'hff);
    send_hit(16'h0100, 1'b0, 32'd5, 8'd0, 1'b1, 16'd20, 8'd3, 1'b0);
    send_hit(16'h0007, 1'b1, 32'd5, 8'd255, 1'b1, 16'd20, 8'd3, 1'b1);
    drain();
    write_reg(REG_DELTA, 8'h00);
    write_reg(REG_UNIQUE, 8'h00);
    send_hit(16'h0100, 1'b0, 32'd5, 8'd4, 1'b1, 16'd20, 8'd0, 1'b0);
    send_hit(16'h0007, 1'b1, 32'd5, 8'd4, 1'b1, 16'd20, 8'd0, 1'b1);
    drain();

    // too many hits: 258 unplaced hits, counts stop at 256
    write_reg(REG_DELTA, 8'd1);
    write_reg(REG_UNIQUE, 8'd60);
    send_idle_pct = 0;
    for (int h = 0; h < 258; h++)
      send_hit(16'h0009, 1'b0, 32'(h), 8'(h), 1'b1, 16'd10, 8'd5, h == 257);
    drain();

    // random part in three idle profiles, register settings change per phase and every 25 reads
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 23 : 0;
      write_reg(REG_DELTA, 8'($urandom_range(4)));
      write_reg(REG_UNIQUE, 8'($urandom));
      for (int r = 0; r < 100; r++) begin
        random_read($urandom_range(1, 8));
        if (r % 25 == 24) begin
          drain();
          write_reg(REG_DELTA, $urandom_range(1) ? 8'($urandom_range(3)) : 8'hff);
          write_reg(REG_UNIQUE, 8'($urandom));
        end
      end
    end

    drain();
    $display("covered %0d hit words and %0d reads, incl. over-long and corner reads",
             words_sent, reads_done);
    $display("three idle profiles and register extremes exercised");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
